// ===== rtl/dipc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipc_pkg
// Shared types and constants of the depth image to point cloud block.
// ----------------------------------------------------------------------------
package dipc_pkg;

  // Default frame size limits
  localparam int unsigned DIPC_MAX_WIDTH  = 4096;
  localparam int unsigned DIPC_MAX_HEIGHT = 4096;

  // Field widths
  localparam int unsigned DEPTH_W  = 24;
  localparam int unsigned POINT_W  = 32;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned CENTER_W = 16;
  localparam int unsigned INV_W    = 24;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 24;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_CENTER_X        = 3'd2,
    REG_CENTER_Y        = 3'd3,
    REG_INVERSE_FOCAL_X = 3'd4,
    REG_INVERSE_FOCAL_Y = 3'd5
  } dipc_reg_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_DONE
  } dipc_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture a new pixel, advance counters
    logic step_a;    // offset times depth
    logic step_b;    // times inverse focal length
    logic out_load;  // round, saturate, fill output register
  } dipc_cmd_t;

endpackage

// ===== rtl/dipc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipc_ctrl
// Sequencer for the multiply stages and the output register handshake.
// ----------------------------------------------------------------------------
module dipc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dipc_pkg::dipc_cmd_t cmd_o
);
  import dipc_pkg::*;

  dipc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic        in_ready;
  logic        accept;

  // Fill the output register once it is empty or being drained
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign in_ready = (state_q == ST_IDLE) || out_load;
  assign accept   = in_valid_i && in_ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MUL_A;
      end
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = accept ? ST_MUL_A : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept;
    cmd_o.step_a   = (state_q == ST_MUL_A);
    cmd_o.step_b   = (state_q == ST_MUL_B);
    cmd_o.out_load = out_load;
    in_ready_o     = in_ready;
    out_valid_o    = out_valid_q;
  end

  // Output valid flag: set on load, clear when the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/dipc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipc_lane
// One axis of the back-projection: offset from the center, two multiply
// stages, then rounding, negation and saturation to signed Q16.16.
// ----------------------------------------------------------------------------
module dipc_lane #(
  parameter int unsigned CW = 12
) (
  input  logic                          clk_i,
  input  logic [CW-1:0]                 pos_i,
  input  logic [dipc_pkg::CENTER_W-1:0] center_i,
  input  logic [dipc_pkg::DEPTH_W-1:0]  depth_i,
  input  logic [dipc_pkg::INV_W-1:0]    inv_i,
  input  dipc_pkg::dipc_cmd_t           cmd_i,
  output logic [dipc_pkg::POINT_W-1:0]  result_o
);
  import dipc_pkg::*;

  localparam int unsigned PW  = CW + 4;
  localparam int unsigned MW  = (PW > CENTER_W) ? PW : CENTER_W;
  localparam int unsigned AW  = MW + DEPTH_W;
  localparam int unsigned LOW = 20;
  localparam int unsigned HW  = AW - LOW;
  localparam int unsigned P1W = HW + INV_W;
  localparam int unsigned P0W = LOW + INV_W;
  localparam int unsigned SW  = AW + INV_W + 1;
  localparam int unsigned MGW = SW - 28;
  localparam logic [SW-1:0] Rnd = {{(SW-28){1'b0}}, 1'b1, 27'b0};

  logic [MW:0]      diff;
  logic [MW-1:0]    mag_d;
  logic [MW-1:0]    mag_q;
  logic             neg_q;
  logic [AW-1:0]    prod_q;
  logic [P1W-1:0]   p1_q;
  logic [P0W-1:0]   p0_q;
  logic [SW-1:0]    sum;
  logic [MGW-1:0]   mag;
  logic             over_pos;
  logic             over_neg;

  // Signed offset pos*16 - center, split into sign and magnitude
  always_comb begin
    diff  = (MW+1)'({pos_i, 4'b0000}) - (MW+1)'(center_i);
    mag_d = diff[MW] ? MW'(~diff + 1'b1) : diff[MW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag_d;
      neg_q <= diff[MW];
    end
    if (cmd_i.step_a) begin
      prod_q <= AW'(mag_q) * AW'(depth_i);
    end
    if (cmd_i.step_b) begin
      p1_q <= P1W'(prod_q[AW-1:LOW]) * P1W'(inv_i);
      p0_q <= P0W'(prod_q[LOW-1:0]) * P0W'(inv_i);
    end
  end

  // Recombine partial products, round half away from zero on the magnitude
  always_comb begin
    sum      = SW'({p1_q, {LOW{1'b0}}}) + SW'(p0_q) + Rnd;
    mag      = sum[SW-1:28];
    over_pos = |mag[MGW-1:31];
    over_neg = (|mag[MGW-1:32]) || (mag[31] && (|mag[30:0]));
  end

  // Apply the opposite sign of the offset and saturate
  always_comb begin
    if (neg_q) begin
      result_o = over_pos ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      result_o = over_neg ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end
  end

endmodule

// ===== rtl/dipc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipc_datapath
// Configuration registers, pixel position counters, the two projection
// lanes and the output register.
// ----------------------------------------------------------------------------
module dipc_datapath #(
  parameter int unsigned MAX_WIDTH  = dipc_pkg::DIPC_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = dipc_pkg::DIPC_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dipc_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [dipc_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic [dipc_pkg::DEPTH_W-1:0]  depth_i,
  input  dipc_pkg::dipc_cmd_t           cmd_i,
  output logic [dipc_pkg::POINT_W-1:0]  point_x_o,
  output logic [dipc_pkg::POINT_W-1:0]  point_y_o,
  output logic [dipc_pkg::POINT_W-1:0]  point_z_o,
  output logic                          end_of_frame_o
);
  import dipc_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned XCW = (CW + 1 > SIZE_W + 1) ? CW + 1 : SIZE_W + 1;
  localparam int unsigned XRW = (RW + 1 > SIZE_W + 1) ? RW + 1 : SIZE_W + 1;

  logic [SIZE_W-1:0]   width_q, height_q;
  logic [CENTER_W-1:0] center_x_q, center_y_q;
  logic [INV_W-1:0]    inv_x_q, inv_y_q;

  logic [CW-1:0]       col_q, col_d;
  logic [RW-1:0]       row_q, row_d;
  logic [XCW-1:0]      width_lim;
  logic [XRW-1:0]      height_lim;
  logic                last_col, last_row;

  logic [DEPTH_W-1:0]  depth_q;
  logic                eof_q;
  logic [POINT_W-1:0]  lane_y, lane_z;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= SIZE_W'(640);
      height_q   <= SIZE_W'(480);
      center_x_q <= CENTER_W'(5120);
      center_y_q <= CENTER_W'(3840);
      inv_x_q    <= INV_W'(21718);
      inv_y_q    <= INV_W'(28957);
    end else if (cfg_we_i) begin
      unique case (dipc_reg_e'(cfg_addr_i))
        REG_IMAGE_WIDTH:     width_q    <= cfg_data_i[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:    height_q   <= cfg_data_i[SIZE_W-1:0];
        REG_CENTER_X:        center_x_q <= cfg_data_i[CENTER_W-1:0];
        REG_CENTER_Y:        center_y_q <= cfg_data_i[CENTER_W-1:0];
        REG_INVERSE_FOCAL_X: inv_x_q    <= cfg_data_i[INV_W-1:0];
        REG_INVERSE_FOCAL_Y: inv_y_q    <= cfg_data_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size: zero acts as one, above the limit acts as the limit
  always_comb begin
    if (width_q == '0) begin
      width_lim = XCW'(1);
    end else if (XCW'(width_q) > XCW'(MAX_WIDTH)) begin
      width_lim = XCW'(MAX_WIDTH);
    end else begin
      width_lim = XCW'(width_q);
    end
    if (height_q == '0) begin
      height_lim = XRW'(1);
    end else if (XRW'(height_q) > XRW'(MAX_HEIGHT)) begin
      height_lim = XRW'(MAX_HEIGHT);
    end else begin
      height_lim = XRW'(height_q);
    end
    last_col = XCW'(col_q) >= (width_lim - XCW'(1));
    last_row = XRW'(row_q) >= (height_lim - XRW'(1));
  end

  // Advance the raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.load) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Hold the pixel's depth and frame flag while the lanes work
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      depth_q <= depth_i;
      eof_q   <= last_col && last_row;
    end
  end

  dipc_lane #(
    .CW (CW)
  ) u_lane_y (
    .clk_i    (clk_i),
    .pos_i    (col_q),
    .center_i (center_x_q),
    .depth_i  (depth_q),
    .inv_i    (inv_x_q),
    .cmd_i    (cmd_i),
    .result_o (lane_y)
  );

  dipc_lane #(
    .CW (RW)
  ) u_lane_z (
    .clk_i    (clk_i),
    .pos_i    (row_q),
    .center_i (center_y_q),
    .depth_i  (depth_q),
    .inv_i    (inv_y_q),
    .cmd_i    (cmd_i),
    .result_o (lane_z)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      point_x_o      <= POINT_W'(depth_q);
      point_y_o      <= lane_y;
      point_z_o      <= lane_z;
      end_of_frame_o <= eof_q;
    end
  end

endmodule

// ===== rtl/depth_image_to_point_cloud.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_image_to_point_cloud
// Pinhole back-projection of a row-major depth stream into 3D points.
// ----------------------------------------------------------------------------
// Each depth sample (unsigned Q8.16 m) becomes one point in signed Q16.16:
// x is the depth, y = -(column - center_x) * depth * inverse_focal_x and
// z = -(row - center_y) * depth * inverse_focal_y, rounded half away from
// zero and saturated. tlast marks the last pixel of a frame. The block takes
// no new pixel before it is through with the last: a pixel is captured,
// multiplied by depth, multiplied by the inverse focal length, and then
// rounded into the output register in the same cycle the next pixel is
// captured. A finished point may wait in the output register while the next
// pixel is already in work. Configuration registers (0 width, 1 height,
// 2 center_x, 3 center_y, 4 inverse_focal_x, 5 inverse_focal_y) must be
// written only while no pixel is in flight; the block itself does not enforce
// this. The position counters keep their place across writes.
module depth_image_to_point_cloud #(
  parameter int unsigned MAX_WIDTH  = dipc_pkg::DIPC_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = dipc_pkg::DIPC_MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [dipc_pkg::CFG_AW-1:0]         cfg_addr_i,
  input  logic [dipc_pkg::CFG_DW-1:0]         cfg_data_i,
  // Depth input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dipc_pkg::DEPTH_W-1:0]        s_axis_tdata,  // [23:0] depth
  // Point output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [3*dipc_pkg::POINT_W-1:0]      m_axis_tdata,  // [31:0] point_x,
                                                             // [63:32] point_y,
                                                             // [95:64] point_z
  output logic                                m_axis_tlast   // end_of_frame
);
  import dipc_pkg::*;

  dipc_cmd_t          cmd;
  logic [POINT_W-1:0] point_x, point_y, point_z;

  dipc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  dipc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .depth_i        (s_axis_tdata),
    .cmd_i          (cmd),
    .point_x_o      (point_x),
    .point_y_o      (point_y),
    .point_z_o      (point_z),
    .end_of_frame_o (m_axis_tlast)
  );

  // Pack the point, first field in the lowest bits
  assign m_axis_tdata = {point_z, point_y, point_x};

endmodule

// ===== tb/depth_image_to_point_cloud_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_image_to_point_cloud_test
// Self-checking bench for the depth image to point cloud block.
// ----------------------------------------------------------------------------
// Streams depth pixels through the block under a series of frame sizes,
// principal points and inverse focal lengths. A scoreboard tracks the pixel
// position, predicts each point (rounding and saturation included) and
// compares every output transfer field by field. A short directed part
// covers the size clamps, rounding ties, saturation, unused register
// indexes and a shrink in the middle of a frame. Random phases follow, with
// bursts of idle cycles on both streams except at the end of the run.
// ----------------------------------------------------------------------------
module depth_image_to_point_cloud_test;
  import dipc_pkg::*;

  // Write addresses that map to no register
  localparam logic [CFG_AW-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_AW-1:0] REG_UNUSED_HI = 3'd7;
  localparam int unsigned ITEM_TARGET = 1250;
  localparam int unsigned CALM_TAIL   = 150;

  typedef struct {
    logic [POINT_W-1:0] x;
    logic [POINT_W-1:0] y;
    logic [POINT_W-1:0] z;
    logic               eof;
  } point_t;

  // Predicts points from accepted depth pixels and checks output transfers
  class point_cloud_scoreboard;
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [INV_W-1:0]    inv_focal_x_reg;
    logic [INV_W-1:0]    inv_focal_y_reg;
    int unsigned         column;
    int unsigned         row;
    point_t              expected_points[$];
    int unsigned         error_count;

    function new();
      width_reg       = 13'd640;
      height_reg      = 13'd480;
      center_x_reg    = 16'd5120;
      center_y_reg    = 16'd3840;
      inv_focal_x_reg = 24'd21718;
      inv_focal_y_reg = 24'd28957;
      column          = 0;
      row             = 0;
      error_count     = 0;
    endfunction

    function void apply_register(logic [CFG_AW-1:0] index, logic [CFG_DW-1:0] value);
      case (index)
        REG_IMAGE_WIDTH:     width_reg       = value[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:    height_reg      = value[SIZE_W-1:0];
        REG_CENTER_X:        center_x_reg    = value[CENTER_W-1:0];
        REG_CENTER_Y:        center_y_reg    = value[CENTER_W-1:0];
        REG_INVERSE_FOCAL_X: inv_focal_x_reg = value[INV_W-1:0];
        REG_INVERSE_FOCAL_Y: inv_focal_y_reg = value[INV_W-1:0];
        default: ;
      endcase
    endfunction

    // Zero acts as one, oversize acts as the limit
    function int unsigned extent(logic [SIZE_W-1:0] value, int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return 32'(value);
    endfunction

    // -(pos - center) * depth * inv, Q.44 product rounded to Q16.16, saturated
    function logic [POINT_W-1:0] back_project(logic [11:0] pos, logic [CENTER_W-1:0] center,
                                              logic [DEPTH_W-1:0] depth,
                                              logic [INV_W-1:0] inv);
      logic signed [17:0] offset;
      logic [16:0]        offset_mag;
      logic [79:0]        product;
      logic [79:0]        mag;
      offset     = $signed({2'b00, pos, 4'b0000}) - $signed({2'b00, center});
      offset_mag = (offset < 0) ? 17'(-offset) : 17'(offset);
      product    = offset_mag * depth * inv;
      mag        = (product + (80'd1 << 27)) >> 28;
      if (offset < 0) return (mag > 80'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      if (mag > 80'h8000_0000) return 32'h8000_0000;
      return 32'd0 - mag[31:0];
    endfunction

    function void note_depth(logic [DEPTH_W-1:0] depth);
      int unsigned w;
      int unsigned h;
      bit          last_col;
      bit          last_row;
      point_t      p;
      w        = extent(width_reg, DIPC_MAX_WIDTH);
      h        = extent(height_reg, DIPC_MAX_HEIGHT);
      last_col = column >= w - 1;
      last_row = row >= h - 1;
      p.x      = {8'd0, depth};
      p.y      = back_project(12'(column), center_x_reg, depth, inv_focal_x_reg);
      p.z      = back_project(12'(row), center_y_reg, depth, inv_focal_y_reg);
      p.eof    = last_col && last_row;
      expected_points.push_back(p);
      // Advance the pixel position
      if (last_col) begin
        column = 0;
        row    = last_row ? 0 : row + 1;
      end else begin
        column = column + 1;
      end
    endfunction

    function void check_point(logic [3*POINT_W-1:0] data, logic last);
      point_t exp_p;
      if (expected_points.size() == 0) begin
        $error("point transfer with none expected: tdata %h tlast %b", data, last);
        error_count++;
        return;
      end
      exp_p = expected_points.pop_front();
      if (data[31:0] !== exp_p.x) begin
        $error("point_x: expected %0d, got %0d", $signed(exp_p.x), $signed(data[31:0]));
        error_count++;
      end
      if (data[63:32] !== exp_p.y) begin
        $error("point_y: expected %0d, got %0d", $signed(exp_p.y), $signed(data[63:32]));
        error_count++;
      end
      if (data[95:64] !== exp_p.z) begin
        $error("point_z: expected %0d, got %0d", $signed(exp_p.z), $signed(data[95:64]));
        error_count++;
      end
      if (last !== exp_p.eof) begin
        $error("end_of_frame: expected %0d, got %0d", exp_p.eof, last);
        error_count++;
      end
    endfunction
  endclass

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0]        cfg_addr_i    = REG_IMAGE_WIDTH;
  logic [CFG_DW-1:0]        cfg_data_i    = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [DEPTH_W-1:0]       s_axis_tdata  = '0;  // [23:0] depth
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [3*POINT_W-1:0]     m_axis_tdata;        // [31:0] x, [63:32] y, [95:64] z
  logic                     m_axis_tlast;        // end_of_frame

  point_cloud_scoreboard sb = new();
  bit          gaps_on    = 1'b1;
  int unsigned sent_items = 0;
  int unsigned sink_hold  = 0;

  depth_image_to_point_cloud i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  always #2 clk_i = ~clk_i;

  // Watch both streams for transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_depth(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_point(m_axis_tdata, m_axis_tlast);
    end
  end

  // Output side: ready with random stall bursts
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= (sink_hold == 1);
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      sink_hold     <= $urandom_range(1, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one depth pixel, hold until it is taken
  task automatic send_depth(input logic [DEPTH_W-1:0] depth);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= depth;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
  endtask

  // Stop feeding and wait until every point has left the block
  task automatic drain_points();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_points.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Drive one write; the caller lowers the enable after the last one
  task automatic write_register(input logic [CFG_AW-1:0] index,
                                input logic [CFG_DW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= index;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.apply_register(index, value);
  endtask

  initial begin
    logic [CFG_AW-1:0]  reg_list[8];
    logic [CFG_DW-1:0]  value;
    logic [DEPTH_W-1:0] depth;
    int unsigned        phase_len;
    reg_list = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_CENTER_X, REG_CENTER_Y,
                 REG_INVERSE_FOCAL_X, REG_INVERSE_FOCAL_Y, REG_UNUSED_LO, REG_UNUSED_HI};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, depth extremes and bit patterns
    send_depth(24'h000000);
    send_depth(24'hFFFFFF);
    send_depth(24'h800000);
    send_depth(24'h555555);
    send_depth(24'hAAAAAA);
    send_depth(24'h000001);
    drain_points();

    // Zero sizes act as one pixel frames; z saturates at the positive limit
    write_register(REG_IMAGE_WIDTH, 24'd0);
    write_register(REG_IMAGE_HEIGHT, 24'd0);
    write_register(REG_CENTER_X, 24'd0);
    write_register(REG_CENTER_Y, 24'hFFFF);
    write_register(REG_INVERSE_FOCAL_X, 24'hFFFFFF);
    write_register(REG_INVERSE_FOCAL_Y, 24'hFFFFFF);
    write_register(REG_UNUSED_LO, 24'h000005);
    write_register(REG_UNUSED_HI, 24'h000007);
    cfg_we_i <= 1'b0;
    send_depth(24'hFFFFFF);
    send_depth(24'hFFFFFF);
    send_depth(24'h000000);
    drain_points();

    // Oversize frame; half LSB ties round away from zero
    write_register(REG_IMAGE_WIDTH, 24'd8191);
    write_register(REG_IMAGE_HEIGHT, 24'd8191);
    write_register(REG_CENTER_X, 24'd16);
    write_register(REG_INVERSE_FOCAL_X, 24'd1);
    cfg_we_i <= 1'b0;
    repeat (4) send_depth(24'h800000);
    drain_points();

    // Shrink mid frame: the column is past the new last position
    write_register(REG_IMAGE_WIDTH, 24'd2);
    write_register(REG_IMAGE_HEIGHT, 24'd2);
    write_register(REG_CENTER_Y, 24'd0);
    cfg_we_i <= 1'b0;
    repeat (3) send_depth(24'h123456);
    drain_points();

    // Random phases, each after a random set of register writes
    while (sent_items < ITEM_TARGET) begin
      gaps_on = (sent_items + CALM_TAIL < ITEM_TARGET) ? ($urandom_range(0, 4) != 0) : 1'b0;
      foreach (reg_list[i]) begin
        if ($urandom_range(0, 1) == 0) begin
          case (reg_list[i])
            REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: begin
              case ($urandom_range(0, 19))
                0:       value = 24'd0;
                1:       value = 24'($urandom_range(4096, 8191));
                2:       value = 24'($urandom());
                default: value = 24'($urandom_range(1, 9));
              endcase
            end
            REG_CENTER_X, REG_CENTER_Y: begin
              value = 24'($urandom_range(0, 1) ? $urandom_range(0, 160)
                                               : $urandom_range(0, 65535));
            end
            REG_INVERSE_FOCAL_X, REG_INVERSE_FOCAL_Y: begin
              value = 24'($urandom_range(0, 1) ? $urandom_range(0, 65536) : $urandom());
            end
            default: begin
              value = 24'($urandom());
            end
          endcase
          if (reg_list[i] < REG_UNUSED_LO || $urandom_range(0, 7) == 0)
            write_register(reg_list[i], value);
        end
      end
      cfg_we_i <= 1'b0;

      phase_len = $urandom_range(10, 60);
      repeat (phase_len) begin
        case ($urandom_range(0, 7))
          0:       depth = 24'h000000;
          1:       depth = 24'hFFFFFF;
          2:       depth = 24'($urandom_range(0, 255));
          default: depth = 24'($urandom());
        endcase
        send_depth(depth);
      end
      drain_points();
    end

    if (sb.error_count == 0) begin
      $display("PASS depth_image_to_point_cloud");
    end else begin
      $display("FAIL depth_image_to_point_cloud");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("FAIL depth_image_to_point_cloud");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dipc_pkg.sv
rtl/dipc_ctrl.sv
rtl/dipc_lane.sv
rtl/dipc_datapath.sv
rtl/depth_image_to_point_cloud.sv
tb/depth_image_to_point_cloud_test.sv
